FILE: hdl/rrws_pkg.sv
// ----------------------------------------------------------------------------
// rrws_pkg
// Shared constants, codes and types of the round-robin wait/ready scheduler.
// ----------------------------------------------------------------------------
package rrws_pkg;

	localparam int MAX_THREADS = 16;
	localparam int ID_W        = 4;
	localparam int MASK_W      = 16;
	localparam int KIND_W      = 3;
	localparam int SLICE_W     = 10;
	localparam int POS_W       = $clog2(MAX_THREADS);
	localparam int CNT_W       = $clog2(MAX_THREADS + 1);

	localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_STOP  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BLOCK = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EXIT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ADD   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_START = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOVE,
		S_APPLY,
		S_RD_LAST,
		S_FILL,
		S_FINAL,
		S_OUT
	} state_t;

	typedef struct packed {
		logic shift;
		logic sel;
	} wait_ctl_t;

endpackage

FILE: hdl/rrws_evt_if.sv
// ----------------------------------------------------------------------------
// rrws_evt_if
// Event channel: valid/ready handshake with the event word.
// ----------------------------------------------------------------------------
interface rrws_evt_if;
	logic                        valid;
	logic                        ready;
	logic [rrws_pkg::KIND_W-1:0] kind;
	logic [rrws_pkg::ID_W-1:0]   thread_id;
	logic [rrws_pkg::MASK_W-1:0] readable_mask;

	modport source(output valid, kind, thread_id, readable_mask, input ready);
	modport sink(input valid, kind, thread_id, readable_mask, output ready);
endinterface

FILE: hdl/rrws_res_if.sv
// ----------------------------------------------------------------------------
// rrws_res_if
// Result channel: valid/ready handshake with the schedule word.
// ----------------------------------------------------------------------------
interface rrws_res_if;
	logic                       valid;
	logic                       ready;
	logic [rrws_pkg::ID_W-1:0]  running_id;
	logic                       running_valid;
	logic                       all_finished;
	logic                       add_rejected;
	logic [rrws_pkg::CNT_W-1:0] ready_count;
	logic [rrws_pkg::CNT_W-1:0] waiting_count;

	modport source(output valid, running_id, running_valid, all_finished, add_rejected,
		ready_count, waiting_count, input ready);
	modport sink(input valid, running_id, running_valid, all_finished, add_rejected,
		ready_count, waiting_count, output ready);
endinterface

FILE: hdl/rrws_ram.sv
// ----------------------------------------------------------------------------
// rrws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hdl/rrws_wait_cell.sv
// ----------------------------------------------------------------------------
// rrws_wait_cell
// One waiting-queue slot: loads a broadcast id or takes its neighbor's id.
// ----------------------------------------------------------------------------
module rrws_wait_cell (
	input  logic                      clk,
	input  rrws_pkg::wait_ctl_t       ctl,
	input  logic [rrws_pkg::ID_W-1:0] wr_data,
	input  logic [rrws_pkg::ID_W-1:0] nbr,
	output logic [rrws_pkg::ID_W-1:0] id_q
);
	import rrws_pkg::*;

	always_ff @(posedge clk) begin
		if (ctl.sel) begin
			id_q <= wr_data;
		end else if (ctl.shift) begin
			id_q <= nbr;
		end
	end
endmodule

FILE: hdl/round_robin_wait_ready_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_wait_ready_scheduler_unit
// Round-robin thread scheduler with ready queue (RAM) and waiting queue
// (shifting row of cells).
//
//   channel   dir  handshake       word
//   evt       in   valid/ready     kind, thread_id, readable_mask
//   res       out  valid/ready     running_id, running_valid, all_finished,
//                                  add_rejected, ready_count, waiting_count
//   cfg       in   cfg_we          cfg_wdata = slice_ticks
//
// One word at a time. The move walk covers W entries, W being the waiting count
// at accept; a block or exit that removes a thread adds the RD_LAST and FILL states.
// The waiting row is walked one entry per cycle and the ready RAM has one
// read port. evt.ready is high while idle, also while a result waits in the
// output register. Reset is asynchronous; slice_ticks resets to 1.
// ----------------------------------------------------------------------------
module round_robin_wait_ready_scheduler_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rrws_pkg::SLICE_W-1:0] cfg_wdata,
	rrws_evt_if.sink                     evt,
	rrws_res_if.source                   res
);
	import rrws_pkg::*;

	state_t              state_q, state_d;
	logic [KIND_W-1:0]   kind_q;
	logic [ID_W-1:0]     tid_q;
	logic [MASK_W-1:0]   mask_q;
	logic [CNT_W-1:0]    rem_q, rem_d;
	logic [CNT_W-1:0]    rl_q, rl_d;
	logic [CNT_W-1:0]    wl_q, wl_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [SLICE_W-1:0]  slice_q, slice_d;
	logic                started_q, started_d;
	logic                rej_q, rej_d;
	logic [SLICE_W-1:0]  slice_ticks_q;

	logic                out_v_q;
	logic [ID_W-1:0]     out_id_q;
	logic                out_rv_q, out_fin_q, out_rej_q;
	logic [CNT_W-1:0]    out_rc_q, out_wc_q;
	logic                out_load;

	logic                ram_we;
	logic [POS_W-1:0]    ram_waddr, ram_raddr;
	logic [ID_W-1:0]     ram_wdata, ram_rdata;

	logic                w_shift, w_wr;
	logic [POS_W-1:0]    w_idx;
	logic [ID_W-1:0]     w_data;
	logic [ID_W-1:0]     cell_q [MAX_THREADS];

	logic [CNT_W-1:0]    rl_m1, wl_m1, pos_inc;
	logic [CNT_W:0]      occ;
	logic [SLICE_W:0]    slice_inc;
	logic [SLICE_W-1:0]  limit;
	logic [POS_W-1:0]    pos_fix;
	logic                ev_acc;

	assign ev_acc    = evt.valid && evt.ready;
	assign evt.ready = (state_q == S_IDLE);
	assign rl_m1     = rl_q - 1'b1;
	assign wl_m1     = wl_q - 1'b1;
	assign pos_inc   = {1'b0, pos_q} + 1'b1;
	assign occ       = {1'b0, rl_q} + {1'b0, wl_q};
	assign slice_inc = {1'b0, slice_q} + 1'b1;
	assign limit     = (slice_ticks_q == '0) ? SLICE_W'(1) : slice_ticks_q;
	assign pos_fix   = ({1'b0, pos_q} >= rl_q) ? '0 : pos_q;

	rrws_ram #(.WIDTH(ID_W), .DEPTH(MAX_THREADS)) u_ready_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	for (genvar i = 0; i < MAX_THREADS; i++) begin : g_wait
		wait_ctl_t       ctl;
		logic [ID_W-1:0] nbr;

		assign ctl.shift = w_shift;
		assign ctl.sel   = w_wr && (w_idx == POS_W'(i));
		if (i == MAX_THREADS - 1) begin : g_last
			assign nbr = cell_q[i];
		end else begin : g_mid
			assign nbr = cell_q[i+1];
		end

		rrws_wait_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.wr_data (w_data),
			.nbr     (nbr),
			.id_q    (cell_q[i])
		);
	end

	always_comb begin
		state_d   = state_q;
		rem_d     = rem_q;
		rl_d      = rl_q;
		wl_d      = wl_q;
		pos_d     = pos_q;
		slice_d   = slice_q;
		started_d = started_q;
		rej_d     = rej_q;
		ram_we    = 1'b0;
		ram_waddr = rl_q[POS_W-1:0];
		ram_wdata = cell_q[0];
		ram_raddr = pos_fix;
		w_shift   = 1'b0;
		w_wr      = 1'b0;
		w_idx     = wl_m1[POS_W-1:0];
		w_data    = cell_q[0];
		out_load  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (ev_acc) begin
					rem_d   = wl_q;
					rej_d   = 1'b0;
					state_d = S_MOVE;
				end
			end
			S_MOVE: begin
				if (rem_q == '0) begin
					state_d = S_APPLY;
				end else begin
					rem_d   = rem_q - 1'b1;
					w_shift = 1'b1;
					if (mask_q[cell_q[0]] && (rl_q < CNT_W'(MAX_THREADS))) begin
						ram_we = 1'b1;
						rl_d   = rl_q + 1'b1;
						wl_d   = wl_m1;
					end else begin
						w_wr = 1'b1;
					end
				end
			end
			S_APPLY: begin
				state_d = S_FINAL;
				unique case (kind_q)
					KIND_TICK: begin
						if (started_q && (rl_q != '0)) begin
							if (slice_inc >= {1'b0, limit}) begin
								slice_d = '0;
								pos_d   = (pos_inc >= rl_q) ? '0 : pos_inc[POS_W-1:0];
							end else begin
								slice_d = slice_inc[SLICE_W-1:0];
							end
						end
					end
					KIND_STOP: begin
						if (started_q) begin
							slice_d = '0;
							if (rl_q == '0) begin
								pos_d = '0;
							end else begin
								pos_d = (pos_inc >= rl_q) ? '0 : pos_inc[POS_W-1:0];
							end
						end
					end
					KIND_BLOCK, KIND_EXIT: begin
						if (started_q) begin
							slice_d = '0;
							if (rl_q == '0) begin
								pos_d = '0;
							end else begin
								pos_d     = pos_fix;
								ram_raddr = pos_fix;
								state_d   = S_RD_LAST;
							end
						end
					end
					KIND_ADD: begin
						if ((occ >= (CNT_W+1)'(MAX_THREADS)) ||
							(rl_q >= CNT_W'(MAX_THREADS))) begin
							rej_d = 1'b1;
						end else begin
							ram_we    = 1'b1;
							ram_wdata = tid_q;
							rl_d      = rl_q + 1'b1;
						end
					end
					KIND_START: begin
						started_d = 1'b1;
						pos_d     = '0;
						slice_d   = '0;
					end
					default: begin
					end
				endcase
			end
			S_RD_LAST: begin
				ram_raddr = rl_m1[POS_W-1:0];
				rl_d      = rl_m1;
				if ((kind_q == KIND_BLOCK) && (wl_q < CNT_W'(MAX_THREADS))) begin
					w_wr   = 1'b1;
					w_idx  = wl_q[POS_W-1:0];
					w_data = ram_rdata;
					wl_d   = wl_q + 1'b1;
				end
				state_d = S_FILL;
			end
			S_FILL: begin
				if ({1'b0, pos_q} == rl_q) begin
					pos_d = '0;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = ram_rdata;
				end
				state_d = S_FINAL;
			end
			S_FINAL: begin
				pos_d     = pos_fix;
				ram_raddr = pos_fix;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (!out_v_q || res.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rem_q         <= '0;
			rl_q          <= '0;
			wl_q          <= '0;
			pos_q         <= '0;
			slice_q       <= '0;
			started_q     <= 1'b0;
			rej_q         <= 1'b0;
			slice_ticks_q <= SLICE_W'(1);
			out_v_q       <= 1'b0;
		end else begin
			state_q   <= state_d;
			rem_q     <= rem_d;
			rl_q      <= rl_d;
			wl_q      <= wl_d;
			pos_q     <= pos_d;
			slice_q   <= slice_d;
			started_q <= started_d;
			rej_q     <= rej_d;
			if (cfg_we) begin
				slice_ticks_q <= cfg_wdata;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_acc) begin
			kind_q <= evt.kind;
			tid_q  <= evt.thread_id;
			mask_q <= evt.readable_mask;
		end
		if (out_load) begin
			out_rv_q  <= started_q && (rl_q != '0);
			out_id_q  <= (started_q && (rl_q != '0)) ? ram_rdata : '0;
			out_fin_q <= (rl_q == '0) && (wl_q == '0);
			out_rej_q <= rej_q;
			out_rc_q  <= rl_q;
			out_wc_q  <= wl_q;
		end
	end

	assign res.valid         = out_v_q;
	assign res.running_id    = out_id_q;
	assign res.running_valid = out_rv_q;
	assign res.all_finished  = out_fin_q;
	assign res.add_rejected  = out_rej_q;
	assign res.ready_count   = out_rc_q;
	assign res.waiting_count = out_wc_q;

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (CNT_W+1)'(MAX_THREADS))
		else $error("queue occupancy exceeds capacity");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (({1'b0, pos_q} < rl_q) || (pos_q == '0)))
		else $error("current position outside ready queue while idle");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		ev_acc |=> (state_q == S_MOVE) && (rem_q == $past(wl_q)))
		else $error("accepted word did not start the move walk");

	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.running_valid && res.all_finished))
		else $error("running and all finished reported together");
endmodule
